// ----- rtl/pmlr_pkg.sv -----
// Package for the pattern match line reporter.
// Holds field structs, the front-to-back record, register indexes and sizes.
// No dependencies.
package pmlr_pkg;

	localparam int PATTERN_MAX  = 16;
	localparam int REPORT_LIMIT = 100;
	localparam int REG_BYTES    = 16;
	localparam int EFF_MAX      = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
	localparam int LEN_W        = 5;
	localparam int FILL_W       = $clog2(PATTERN_MAX + 1);
	localparam int BLOCK_W      = $clog2(EFF_MAX + 1);
	localparam int NL_W         = $clog2(REG_BYTES + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] NEWLINE = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_file;
	} byte_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] line_number;
		logic [31:0] match_total;
		logic        final_item;
	} result_item_t;

	// One classified byte: a match report, a summary, or both.
	typedef struct packed {
		logic        report;
		logic        eof;
		logic [31:0] line;
		logic [31:0] total;
	} record_t;

endpackage

// ----- rtl/pmlr_front.sv -----
// Front part: configuration registers, byte window, match detection.
// Queues a record per reporting or end-of-file byte. Uses pmlr_pkg.
module pmlr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmlr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmlr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            accept,
	input  pmlr_pkg::byte_item_t            item,
	output logic                            push,
	output pmlr_pkg::record_t               rec
);
	import pmlr_pkg::*;

	logic [63:0]                    pattern_low_q;
	logic [63:0]                    pattern_high_q;
	logic [LEN_W-1:0]               pattern_length_q;
	logic [PATTERN_MAX-1:0][7:0]    window_q;
	logic [FILL_W-1:0]              filled_q;
	logic [31:0]                    line_q;
	logic [31:0]                    hits_q;
	logic [BLOCK_W-1:0]             blocked_q;

	logic [REG_BYTES-1:0][7:0]      pat;
	logic [LEN_W-1:0]               len_eff;
	logic [NL_W-1:0]                nl_count;
	logic [PATTERN_MAX-1:0][7:0]    window_n;
	logic [FILL_W-1:0]              filled_n;
	logic [31:0]                    line_n;
	logic                           hit;
	logic [BLOCK_W-1:0]             blocked_n;
	logic [31:0]                    hits_n;
	logic                           report;

	assign pat = {pattern_high_q, pattern_low_q};

	always_comb begin
		if (pattern_length_q > LEN_W'(EFF_MAX)) begin
			len_eff = LEN_W'(EFF_MAX);
		end else begin
			len_eff = pattern_length_q;
		end
	end

	always_comb begin
		nl_count = '0;
		for (int k = 0; k < REG_BYTES; k++) begin
			if (LEN_W'(k) < len_eff && pat[k] == NEWLINE) begin
				nl_count = nl_count + NL_W'(1);
			end
		end
	end

	always_comb begin
		window_n = {window_q[PATTERN_MAX-2:0], item.byte_value};
		filled_n = (filled_q < FILL_W'(PATTERN_MAX)) ? filled_q + FILL_W'(1) : filled_q;
		line_n   = line_q + ((item.byte_value == NEWLINE) ? 32'd1 : 32'd0);
	end

	// Window slot j holds the byte that must equal pattern byte len-1-j.
	always_comb begin
		logic [LEN_W-1:0] idx;
		logic             eq;
		eq  = 1'b1;
		idx = '0;
		for (int j = 0; j < EFF_MAX; j++) begin
			idx = LEN_W'(len_eff - LEN_W'(1) - LEN_W'(j));
			if (LEN_W'(j) < len_eff && window_n[j] != pat[idx[$clog2(REG_BYTES)-1:0]]) begin
				eq = 1'b0;
			end
		end
		hit       = 1'b0;
		blocked_n = blocked_q;
		if (blocked_q != '0) begin
			blocked_n = blocked_q - BLOCK_W'(1);
		end else if (len_eff != '0 && FILL_W'(len_eff) <= filled_n && eq) begin
			hit       = 1'b1;
			blocked_n = BLOCK_W'(len_eff - LEN_W'(1));
		end
	end

	always_comb begin
		report = hit && (hits_q < 32'(REPORT_LIMIT));
		hits_n = (hit && hits_q != 32'hFFFF_FFFF) ? hits_q + 32'd1 : hits_q;
	end

	assign push       = accept && (report || item.end_of_file);
	assign rec.report = report;
	assign rec.eof    = item.end_of_file;
	assign rec.line   = line_n - 32'(nl_count);
	assign rec.total  = hits_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clear the search state after the last byte of a file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			filled_q  <= '0;
			line_q    <= 32'd1;
			hits_q    <= '0;
			blocked_q <= '0;
		end else if (accept) begin
			if (item.end_of_file) begin
				window_q  <= '0;
				filled_q  <= '0;
				line_q    <= 32'd1;
				hits_q    <= '0;
				blocked_q <= '0;
			end else begin
				window_q  <= window_n;
				filled_q  <= filled_n;
				line_q    <= line_n;
				hits_q    <= hits_n;
				blocked_q <= blocked_n;
			end
		end
	end

endmodule

// ----- rtl/pmlr_queue.sv -----
// Small record queue between the front and back parts.
// Registered entries, head and tail pointers, fill count. Uses pmlr_pkg.
module pmlr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pmlr_pkg::record_t push_rec,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output pmlr_pkg::record_t head_rec
);
	import pmlr_pkg::*;

	record_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/pmlr_back.sv -----
// Back part: expands each queued record into one or two result transfers.
// Uses pmlr_pkg.
module pmlr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  pmlr_pkg::record_t      head_rec,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_ready,
	output pmlr_pkg::result_item_t result_item
);
	import pmlr_pkg::*;

	// Set once the match report of a two-result record has gone out.
	logic report_done_q;
	logic send_report;
	logic xfer;

	assign send_report  = head_rec.report && !report_done_q;
	assign result_valid = head_valid;
	assign xfer         = result_valid && result_ready;
	assign pop          = xfer && !(send_report && head_rec.eof);

	always_comb begin
		if (send_report) begin
			result_item.result_kind = KIND_MATCH;
			result_item.line_number = head_rec.line;
			result_item.final_item  = !head_rec.eof;
		end else begin
			result_item.result_kind = KIND_SUMMARY;
			result_item.line_number = '0;
			result_item.final_item  = 1'b1;
		end
		result_item.match_total = head_rec.total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_done_q <= 1'b0;
		end else if (pop) begin
			report_done_q <= 1'b0;
		end else if (xfer) begin
			report_done_q <= 1'b1;
		end
	end

endmodule

// ----- rtl/pattern_match_line_reporter_unit.sv -----
// Pattern match line reporter, top level.
// Instantiates pmlr_front, pmlr_queue and pmlr_back; uses pmlr_pkg.
//
// Usage:
//   The byte channel (byte_valid/byte_ready/byte_item) carries one file byte
//   per transfer; end_of_file marks the last byte of a file. The result
//   channel (result_valid/result_ready/result_item) carries one match report
//   per hit for the first REPORT_LIMIT hits of a file, each with the line on
//   which the hit starts, and one summary after the last byte.
//   The configuration port writes pattern_low, pattern_high and
//   pattern_length by index when cfg_we is high; write only while idle.
//   Throughput: one byte per cycle while the queue is not full; the front
//   compares the whole window combinationally. A byte causing a report
//   and a summary needs two result transfers; the back end emits one per
//   cycle while result_ready is high. With the queue empty, a result is
//   offered in the cycle after its byte transfer; queued results go first.
//   Stalls: a four-entry record queue sits between front and back and
//   byte_ready drops while it is full, so a stalled receiver holds off all
//   bytes once four records are pending; until then bytes keep flowing.
//   Reset: patterns clear with pattern_length one; search state and queue clear.
module pattern_match_line_reporter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_ready,
	input  pmlr_pkg::byte_item_t            byte_item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output pmlr_pkg::result_item_t          result_item,
	input  logic                            cfg_we,
	input  logic [pmlr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmlr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pmlr_pkg::*;

	logic    accept;
	logic    push;
	record_t push_rec;
	logic    full;
	logic    pop;
	logic    head_valid;
	record_t head_rec;

	// Hold off bytes while the queue cannot take another record.
	assign byte_ready = !full;
	assign accept     = byte_valid && byte_ready;

	// Classify each transfer; reporting and end-of-file bytes become records.
	pmlr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (byte_item),
		.push      (push),
		.rec       (push_rec)
	);

	// Decouple classification from the result handshake.
	pmlr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	// Advance through the records, one result per transfer.
	pmlr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_rec     (head_rec),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule
